### hw/rtl/region_pixel_blit_blend_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the region pixel blit/blend core
// Shared clocking and reset disable for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef REGION_PIXEL_BLIT_BLEND_CORE_ASSERT_SVH
`define REGION_PIXEL_BLIT_BLEND_CORE_ASSERT_SVH

// property must hold in the same cycle as its antecedent
`define RPBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RPBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rpbb_pkg.sv
// ----------------------------------------------------------------------------
// rpbb_pkg
// Types, widths and codes shared by the region pixel blit/blend core.
// ----------------------------------------------------------------------------
package rpbb_pkg;

  // texture geometry
  localparam int unsigned MAX_WIDTH   = 64;
  localparam int unsigned MAX_HEIGHT  = 64;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  // field widths
  localparam int unsigned CH_W     = 8;
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned DIM_W    = 7;   // widths and heights
  localparam int unsigned CUR_W    = 6;   // offsets and cursor
  localparam int unsigned WGT_W    = 9;   // Q8 weight
  localparam int unsigned CALC_W   = 2 * DIM_W;
  localparam int unsigned SQ_W     = 2 * CUR_W;
  localparam int unsigned PROD_W   = 2 * SQ_W;

  // unity weight in Q8
  localparam logic [WGT_W-1:0] W_ONE = WGT_W'(256);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = WGT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_WIDTH     = 4'd0,
    CFG_TEX_HEIGHT    = 4'd1,
    CFG_REGION_X      = 4'd2,
    CFG_REGION_Y      = 4'd3,
    CFG_REGION_W      = 4'd4,
    CFG_REGION_H      = 4'd5,
    CFG_CIRCULAR_MODE = 4'd6,
    CFG_BLEND_WEIGHT  = 4'd7
  } cfg_idx_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_type_e;

  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_OUT_OF_BOUNDS = 1'b1
  } status_e;

  // one pixel: [2] red, [1] green, [0] blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  localparam int unsigned CH_RED   = 2;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 0;

endpackage

### hw/rtl/rpbb_if.sv
// ----------------------------------------------------------------------------
// rpbb interfaces
// Request, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------

// request channel: one pixel item
interface rpbb_req_if import rpbb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;

  modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

// result channel: one item per request
interface rpbb_rsp_if import rpbb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            was_written;
  logic            status;
  logic            last_of_region;

  modport source (output valid, out_red, out_green, out_blue, was_written, status,
                  last_of_region, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, was_written, status,
                  last_of_region, output ready);
endinterface

// configuration write channel
interface rpbb_cfg_if import rpbb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/rpbb_tex_ram.sv
// ----------------------------------------------------------------------------
// rpbb_tex_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rpbb_tex_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 24,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/rpbb_blend.sv
// ----------------------------------------------------------------------------
// rpbb_blend
// Per-channel Q8 blend of new and stored pixel, registered result.
// ----------------------------------------------------------------------------
module rpbb_blend import rpbb_pkg::*; (
  input  logic             clk_i,
  input  pix_t             new_pix_i,
  input  pix_t             old_pix_i,
  input  logic [WGT_W-1:0] weight_i,
  output pix_t             blend_o
);

  localparam int unsigned SUM_W = CH_W + WGT_W;

  logic [WGT_W-1:0] w_old;
  logic [WGT_W-1:0] w_new;
  pix_t             blend_d;
  pix_t             blend_q;

  // weights above unity saturate
  assign w_old = (weight_i > W_ONE) ? W_ONE : weight_i;
  assign w_new = W_ONE - w_old;

  // one lane per colour channel, truncating shift by eight
  always_comb begin
    logic [SUM_W-1:0] acc;
    blend_d = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      acc = SUM_W'(new_pix_i[i]) * SUM_W'(w_new) + SUM_W'(old_pix_i[i]) * SUM_W'(w_old);
      blend_d[i] = acc[CH_W +: CH_W];
    end
  end

  always_ff @(posedge clk_i) begin
    blend_q <= blend_d;
  end

  assign blend_o = blend_q;

endmodule

### hw/rtl/rpbb_ellipse.sv
// ----------------------------------------------------------------------------
// rpbb_ellipse
// Two-stage cross-multiplied test against the ellipse inscribed in the region.
// ----------------------------------------------------------------------------
module rpbb_ellipse import rpbb_pkg::*; (
  input  logic             clk_i,
  input  logic [CUR_W-1:0] col_i,
  input  logic [CUR_W-1:0] row_i,
  input  logic [DIM_W-1:0] region_w_i,
  input  logic [DIM_W-1:0] region_h_i,
  output logic             inside_o
);

  logic [CUR_W-1:0]  half_a;
  logic [CUR_W-1:0]  half_b;
  logic [CUR_W-1:0]  dx;
  logic [CUR_W-1:0]  dy;

  logic [SQ_W-1:0]   dx2_q, dy2_q, a2_q, b2_q;
  logic              degen_q;
  logic [PROD_W-1:0] px_q, py_q, pab_q;
  logic              degen2_q;
  logic [PROD_W:0]   lhs;

  // half sizes, truncated, and distance from centre
  assign half_a = region_w_i[DIM_W-1:1];
  assign half_b = region_h_i[DIM_W-1:1];
  assign dx     = (col_i > half_a) ? (col_i - half_a) : (half_a - col_i);
  assign dy     = (row_i > half_b) ? (row_i - half_b) : (half_b - row_i);

  // stage 1: squares
  always_ff @(posedge clk_i) begin
    dx2_q   <= SQ_W'(dx) * SQ_W'(dx);
    dy2_q   <= SQ_W'(dy) * SQ_W'(dy);
    a2_q    <= SQ_W'(half_a) * SQ_W'(half_a);
    b2_q    <= SQ_W'(half_b) * SQ_W'(half_b);
    degen_q <= (half_a == '0) || (half_b == '0);
  end

  // stage 2: cross products
  always_ff @(posedge clk_i) begin
    px_q     <= PROD_W'(dx2_q) * PROD_W'(b2_q);
    py_q     <= PROD_W'(dy2_q) * PROD_W'(a2_q);
    pab_q    <= PROD_W'(a2_q) * PROD_W'(b2_q);
    degen2_q <= degen_q;
  end

  // degenerate ellipse contains nothing
  assign lhs      = (PROD_W + 1)'(px_q) + (PROD_W + 1)'(py_q);
  assign inside_o = !degen2_q && (lhs <= (PROD_W + 1)'(pab_q));

endmodule

### hw/rtl/region_pixel_blit_blend_core.sv
// ----------------------------------------------------------------------------
// region_pixel_blit_blend_core
// Texture memory with a row-major region cursor; per-item pixel read or
// blended write, optionally limited to the inscribed ellipse.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | accept
//  req_i    | in  | req_type, in_red, in_green, in_blue            | valid & ready
//  rsp_o    | out | out_red/green/blue, was_written, status, last  | valid & ready
//  cfg_i    | in  | index, data                                    | valid & ready
//
//  An item passes through accept, address and memory read, blend and
//  ellipse products, write back; the read-modify-write of the single texture
//  memory sets this order, and no new item is accepted before write back.
//  After reset a clearing pass zeroes all 4096 texels of the memory; no item is
//  accepted meanwhile, configuration writes are taken throughout.
//  A result waits in the output register while the next item is accepted;
//  write back holds while that register is still full.
// ----------------------------------------------------------------------------
module region_pixel_blit_blend_core import rpbb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpbb_req_if.sink   req_i,
  rpbb_rsp_if.source rsp_o,
  rpbb_cfg_if.sink   cfg_i
);

`include "region_pixel_blit_blend_core_assert.svh"

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_MUL,
    S_WB
  } state_e;

  // configuration registers
  logic [DIM_W-1:0] tex_width_q, tex_height_q, region_w_q, region_h_q;
  logic [CUR_W-1:0] region_x_q, region_y_q;
  logic             circular_mode_q;
  logic [WGT_W-1:0] blend_weight_q;

  // control
  state_e           state_q;
  logic [ADDR_W-1:0] clr_q;
  logic [CUR_W-1:0] col_q, row_q;
  logic             fits_q;
  logic             rsp_valid_q;

  // payload
  logic             req_type_q;
  pix_t             new_q;
  pix_t             old_q;
  logic [ADDR_W-1:0] addr_q;
  pix_t             rsp_pix_q;
  logic             rsp_written_q, rsp_status_q, rsp_last_q;

  logic             req_acc, cfg_acc, out_free, wb_go;
  logic             fits, stray, in_ellipse, do_write, last;
  logic [DIM_W:0]   x_end, y_end;
  logic [DIM_W-1:0] col_p1, row_p1, row_abs, col_abs;
  logic [CALC_W-1:0] addr_calc;
  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  pix_t             ram_wdata, ram_rdata, blend_pix;

  assign req_acc  = req_i.valid && req_i.ready;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign wb_go    = (state_q == S_WB) && out_free;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // region bounds check against the texture in use
  assign x_end = (DIM_W + 1)'(region_x_q) + (DIM_W + 1)'(region_w_q);
  assign y_end = (DIM_W + 1)'(region_y_q) + (DIM_W + 1)'(region_h_q);
  assign fits  = (region_w_q != '0) && (region_h_q != '0) &&
                 (tex_width_q != '0) && (tex_height_q != '0) &&
                 (tex_width_q <= DIM_W'(MAX_WIDTH)) &&
                 (tex_height_q <= DIM_W'(MAX_HEIGHT)) &&
                 (x_end <= (DIM_W + 1)'(tex_width_q)) &&
                 (y_end <= (DIM_W + 1)'(tex_height_q));
  assign stray = (DIM_W'(col_q) >= region_w_q) || (DIM_W'(row_q) >= region_h_q);

  // cursor step and wrap
  assign col_p1 = DIM_W'(col_q) + DIM_W'(1);
  assign row_p1 = DIM_W'(row_q) + DIM_W'(1);
  assign last   = (col_p1 >= region_w_q) && (row_p1 >= region_h_q);

  // texel address of the cursor pixel
  assign row_abs   = DIM_W'(region_y_q) + DIM_W'(row_q);
  assign col_abs   = DIM_W'(region_x_q) + DIM_W'(col_q);
  assign addr_calc = CALC_W'(row_abs) * CALC_W'(tex_width_q) + CALC_W'(col_abs);

  // write decision at write back
  assign do_write = fits_q && (req_type_q == REQ_WRITE) && (!circular_mode_q || in_ellipse);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q     <= DIM_W'(64);
      tex_height_q    <= DIM_W'(64);
      region_x_q      <= '0;
      region_y_q      <= '0;
      region_w_q      <= DIM_W'(1);
      region_h_q      <= DIM_W'(1);
      circular_mode_q <= 1'b0;
      blend_weight_q  <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_i.index)
        CFG_TEX_WIDTH:     tex_width_q     <= cfg_i.data[DIM_W-1:0];
        CFG_TEX_HEIGHT:    tex_height_q    <= cfg_i.data[DIM_W-1:0];
        CFG_REGION_X:      region_x_q      <= cfg_i.data[CUR_W-1:0];
        CFG_REGION_Y:      region_y_q      <= cfg_i.data[CUR_W-1:0];
        CFG_REGION_W:      region_w_q      <= cfg_i.data[DIM_W-1:0];
        CFG_REGION_H:      region_h_q      <= cfg_i.data[DIM_W-1:0];
        CFG_CIRCULAR_MODE: circular_mode_q <= cfg_i.data[0];
        CFG_BLEND_WEIGHT:  blend_weight_q  <= cfg_i.data[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, cursor and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      fits_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_acc) begin
            fits_q <= fits;
            if (fits && stray) begin
              col_q <= '0;
              row_q <= '0;
            end
            state_q <= S_ADDR;
          end
        end
        S_ADDR: state_q <= S_MUL;
        S_MUL:  state_q <= S_WB;
        S_WB: begin
          if (out_free) begin
            rsp_valid_q <= 1'b1;
            if (fits_q) begin
              if (col_p1 >= region_w_q) begin
                col_q <= '0;
                row_q <= last ? '0 : row_p1[CUR_W-1:0];
              end else begin
                col_q <= col_p1[CUR_W-1:0];
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // any register write rewinds the cursor
      if (cfg_acc && (cfg_i.index <= CFG_BLEND_WEIGHT)) begin
        col_q <= '0;
        row_q <= '0;
      end
    end
  end

  // item payload and result registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_type_q      <= req_i.req_type;
      new_q[CH_RED]   <= req_i.in_red;
      new_q[CH_GREEN] <= req_i.in_green;
      new_q[CH_BLUE]  <= req_i.in_blue;
    end
    if (state_q == S_ADDR) begin
      addr_q <= addr_calc[ADDR_W-1:0];
    end
    if (state_q == S_MUL) begin
      old_q <= ram_rdata;
    end
    if (wb_go) begin
      rsp_pix_q     <= !fits_q ? '0 : (do_write ? blend_pix : old_q);
      rsp_written_q <= do_write;
      rsp_status_q  <= fits_q ? STATUS_OK : STATUS_OUT_OF_BOUNDS;
      rsp_last_q    <= fits_q && last;
    end
  end

  // memory port: clearing pass or write back
  assign ram_we    = (state_q == S_CLEAR) || (wb_go && do_write);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : blend_pix;

  rpbb_tex_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH ($bits(pix_t))
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_calc[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  rpbb_blend u_blend (
    .clk_i     (clk_i),
    .new_pix_i (new_q),
    .old_pix_i (ram_rdata),
    .weight_i  (blend_weight_q),
    .blend_o   (blend_pix)
  );

  rpbb_ellipse u_ellipse (
    .clk_i      (clk_i),
    .col_i      (col_q),
    .row_i      (row_q),
    .region_w_i (region_w_q),
    .region_h_i (region_h_q),
    .inside_o   (in_ellipse)
  );

  // result outputs
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.out_red        = rsp_pix_q[CH_RED];
  assign rsp_o.out_green      = rsp_pix_q[CH_GREEN];
  assign rsp_o.out_blue       = rsp_pix_q[CH_BLUE];
  assign rsp_o.was_written    = rsp_written_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.last_of_region = rsp_last_q;

  // checks
  `RPBB_ASSERT(a_item_write_needs_fit, (ram_we && state_q != S_CLEAR) |-> (fits_q && state_q == S_WB), "texel write outside write back or with region out of bounds")
  `RPBB_ASSERT(a_error_result_empty, (rsp_o.valid && rsp_o.status) |-> (rsp_o.out_red == '0 && rsp_o.out_green == '0 && rsp_o.out_blue == '0 && !rsp_o.was_written && !rsp_o.last_of_region), "bounds error item carries data")
  `RPBB_ASSERT_NEXT(a_cursor_in_region, (wb_go && fits_q), (DIM_W'(col_q) < region_w_q && DIM_W'(row_q) < region_h_q), "cursor left the region after an item")

endmodule
